// ===== design/shld_pkg.sv =====
package shld_pkg;

    // Register indexes of the configuration port.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_TYPE = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [7:0] SYNC_BYTE_RST   = 8'h5a;
    localparam logic [7:0] WANTED_TYPE_RST = 8'h15;

    // Frame layout: two sync bytes, type, length, payload, trailer.
    localparam int POS_TYPE    = 2;
    localparam int POS_LEN     = 3;
    localparam int OVERHEAD    = 5;
    localparam int LEN_SUM_W   = 9;
    localparam int FRAME_BYTES = 8;

    // Input item kinds.
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // One result item.
    typedef struct packed {
        logic                       frame_ready;
        logic [FRAME_BYTES*8-1:0]   frame_bytes;
        logic                       frame_latched;
        logic                       frame_dropped;
    } res_t;

endpackage

// ===== design/shld_in_if.sv =====
interface shld_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

// ===== design/shld_out_if.sv =====
interface shld_out_if;
    logic        valid;
    logic        ready;
    logic        frame_ready;
    logic [63:0] frame_bytes;
    logic        frame_latched;
    logic        frame_dropped;

    modport source (output valid, output frame_ready, output frame_bytes,
                    output frame_latched, output frame_dropped, input ready);
    modport sink (input valid, input frame_ready, input frame_bytes,
                  input frame_latched, input frame_dropped, output ready);
endinterface

// ===== design/shld_out_buf.sv =====
module shld_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  shld_pkg::res_t   in_data,
    shld_out_if.source       res
);
    import shld_pkg::*;

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_data_reg;
    res_t skid_data_reg;
    logic out_fire;
    logic in_fire;

    assign out_fire = out_valid_reg & res.ready;
    assign in_ready = ~skid_valid_reg;
    assign in_fire  = in_valid & in_ready;

    // Valid flags of the output register and the skid stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload moves: a new item goes to the output register when it is free,
    // otherwise it waits in the skid stage.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_data_reg <= in_data;
            end
            else
            begin
                skid_data_reg <= in_data;
            end
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.frame_ready   = out_data_reg.frame_ready;
    assign res.frame_bytes   = out_data_reg.frame_bytes;
    assign res.frame_latched = out_data_reg.frame_latched;
    assign res.frame_dropped = out_data_reg.frame_dropped;

    // The skid stage holds an item only behind a full output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while output register empty");

    // A waiting skid item moves up as soon as the output is taken.
    a_skid_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && res.ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid item did not move to the output register");

    // Nothing enters while the skid stage is occupied.
    a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !in_ready)
        else $error("input accepted with skid stage full");
endmodule

// ===== design/sync_header_length_deframer.sv =====
// Output: a result is registered in the output register, or in the skid stage
// if that is full. Throughput: one item per cycle while the skid stage is empty;
// the byte counter and head store update on accept; two entries absorb stalls.
// Reset: asynchronous, active low; clears the counter, head store, latched frame
// and ready flag, and loads the sync byte and wanted type with their defaults.
module sync_header_length_deframer #(
    parameter int MAX_FRAME   = 20,
    parameter int LATCH_BYTES = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    shld_in_if.sink                        rx,
    shld_out_if.source                     res,
    input  logic                           cfg_we,
    input  logic [shld_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);
    import shld_pkg::*;

    localparam int CW = $clog2(MAX_FRAME + 1);

    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [CW-1:0]            count_inc;
    logic [7:0]               head_reg [LATCH_BYTES];
    logic [7:0]               head_next [LATCH_BYTES];
    logic [FRAME_BYTES*8-1:0] latched_reg;
    logic [FRAME_BYTES*8-1:0] latched_next;
    logic [FRAME_BYTES*8-1:0] capture;
    logic                     ready_flag_reg;
    logic                     ready_flag_next;
    logic [7:0]               sync_reg;
    logic [7:0]               wanted_reg;
    logic [LEN_SUM_W-1:0]     len_sum;
    logic                     latch_now;
    logic                     drop_now;
    logic                     in_fire;
    logic                     buf_ready;
    res_t                     result;

    assign rx.ready = buf_ready;
    assign in_fire  = rx.valid & buf_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg   <= SYNC_BYTE_RST;
            wanted_reg <= WANTED_TYPE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SYNC_BYTE:   sync_reg   <= cfg_data;
                CFG_WANTED_TYPE: wanted_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Head store write: the new byte lands at the current position if it is
    // one of the kept head bytes.
    always_comb
    begin
        for (int k = 0; k < LATCH_BYTES; k++)
        begin
            head_next[k] = head_reg[k];
            if (count_reg == CW'(k))
            begin
                head_next[k] = rx.rx_byte;
            end
        end
    end

    assign count_inc = count_reg + CW'(1);
    assign len_sum   = LEN_SUM_W'(head_next[POS_LEN]) + LEN_SUM_W'(OVERHEAD);

    // Captured frame: bytes past the frame length read as zero.
    always_comb
    begin
        capture = '0;
        for (int k = 0; k < LATCH_BYTES; k++)
        begin
            if (CW'(k) < count_inc)
            begin
                capture[8*k +: 8] = head_next[k];
            end
        end
    end

    // Frame tracking for one item.
    always_comb
    begin
        count_next      = count_reg;
        latched_next    = latched_reg;
        ready_flag_next = ready_flag_reg;
        latch_now       = 1'b0;
        drop_now        = 1'b0;
        if (rx.kind == KIND_CLEAR)
        begin
            ready_flag_next = 1'b0;
        end
        else
        begin
            count_next = count_inc;
            if (count_inc == CW'(1) && rx.rx_byte != sync_reg)
            begin
                count_next = '0;
            end
            else if (count_inc == CW'(2) && rx.rx_byte != sync_reg)
            begin
                count_next = '0;
            end
            else if (count_inc == CW'(4))
            begin
                // Length known: a frame that cannot fit is dropped at once.
                if (len_sum > LEN_SUM_W'(MAX_FRAME))
                begin
                    drop_now   = 1'b1;
                    count_next = '0;
                end
            end
            else if (count_inc >= CW'(OVERHEAD) && LEN_SUM_W'(count_inc) == len_sum)
            begin
                if (head_next[POS_TYPE] == wanted_reg && !ready_flag_reg)
                begin
                    latched_next    = capture;
                    ready_flag_next = 1'b1;
                    latch_now       = 1'b1;
                end
                else
                begin
                    drop_now = 1'b1;
                end
                count_next = '0;
            end
        end
    end

    // Frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            latched_reg    <= '0;
            ready_flag_reg <= 1'b0;
            for (int k = 0; k < LATCH_BYTES; k++)
            begin
                head_reg[k] <= '0;
            end
        end
        else if (in_fire)
        begin
            count_reg      <= count_next;
            latched_reg    <= latched_next;
            ready_flag_reg <= ready_flag_next;
            if (rx.kind == KIND_BYTE)
            begin
                for (int k = 0; k < LATCH_BYTES; k++)
                begin
                    head_reg[k] <= head_next[k];
                end
            end
        end
    end

    assign result.frame_ready   = ready_flag_next;
    assign result.frame_bytes   = latched_next;
    assign result.frame_latched = latch_now;
    assign result.frame_dropped = drop_now;

    shld_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (buf_ready),
        .in_data  (result),
        .res      (res)
    );

    // The position never reaches the largest frame length between items.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CW'(MAX_FRAME))
        else $error("byte counter out of range");

    // A latched frame sets the ready flag and restarts the counter.
    a_latch_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && latch_now) |=> (ready_flag_reg && count_reg == '0))
        else $error("latched frame did not set the ready flag");

    // A frame is never latched while the flag is still set.
    a_no_latch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        latch_now |-> !ready_flag_reg)
        else $error("frame latched while ready flag busy");

    // A clear item always leaves the flag low.
    a_clear_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && rx.kind == KIND_CLEAR) |=> !ready_flag_reg)
        else $error("clear item did not clear the ready flag");
endmodule
